@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers, clocked on clk_i and held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define PRFA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// a stalled valid keeps its data
`define PRFA_ASSERT_HOLD(name, vld, rdy, data, msg) \
  `PRFA_ASSERT(name, (vld) && !(rdy) |=> (vld) && $stable(data), msg)

`endif

@@ rtl/prfa_pkg.sv @@
// ----------------------------------------------------------------------------
// prfa_pkg
// shared types, constants and helpers of the plane rotate/flip address unit
// ----------------------------------------------------------------------------
package prfa_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned CNT_W   = 12;
  localparam int unsigned IDX_W   = 24;
  localparam int unsigned OFS_W   = 14;
  localparam int unsigned PIX_W   = 8;

  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  // queue plus the four back-end stages
  localparam int unsigned MAX_IN_FLIGHT = QUEUE_DEPTH + 4;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] REG_PLANE_WIDTH     = 3'd0;
  localparam logic [2:0] REG_PLANE_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_QUARTER_TURNS   = 3'd2;
  localparam logic [2:0] REG_FLIP_VERTICAL   = 3'd3;
  localparam logic [2:0] REG_FLIP_HORIZONTAL = 3'd4;

  localparam logic [DIM_W-1:0] RST_PLANE_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RST_PLANE_HEIGHT = DIM_W'(480);

  typedef struct packed {
    logic [DIM_W-1:0] plane_width;
    logic [DIM_W-1:0] plane_height;
    logic [1:0]       quarter_turns;
    logic             flip_vertical;
    logic             flip_horizontal;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic             last;
  } q_item_t;

  // zero reads as one, anything above the maximum as the maximum
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

endpackage

@@ rtl/plane_rotate_flip_addressing_unit.sv @@
// ----------------------------------------------------------------------------
// plane_rotate_flip_addressing_unit
// destination addresses for rotating and mirroring one image plane
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order while the queue has room and
// returns one result per pixel, in order, one per clock when the output side
// keeps up. A result passes through the two-entry queue behind the row/column
// counters, then through four back-end stages (local coordinates, offset
// terms, the width-by-row multiplier, the final add into
// the output register). Up to six pixels can be in flight, so a stalled output
// blocks the input only after the queue fills. Plane size and rotation are set
// through the register port and must not change while pixels are in flight.
module plane_rotate_flip_addressing_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // pixel input
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [prfa_pkg::PIX_W-1:0]  pixel_in_i,
  input  logic                        start_of_plane_i,
  // write address output
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [prfa_pkg::IDX_W-1:0]  dest_index_o,
  output logic [prfa_pkg::PIX_W-1:0]  pixel_out_o,
  output logic                        write_enable_o,
  output logic                        end_of_plane_o,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [prfa_pkg::ADDR_W-1:0] paddr,
  input  logic [prfa_pkg::DATA_W-1:0] pwdata,
  output logic [prfa_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import prfa_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] reg_sel;
  logic       reg_wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.plane_width     <= RST_PLANE_WIDTH;
      cfg_q.plane_height    <= RST_PLANE_HEIGHT;
      cfg_q.quarter_turns   <= '0;
      cfg_q.flip_vertical   <= 1'b0;
      cfg_q.flip_horizontal <= 1'b0;
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_PLANE_WIDTH:     cfg_q.plane_width     <= pwdata[DIM_W-1:0];
        REG_PLANE_HEIGHT:    cfg_q.plane_height    <= pwdata[DIM_W-1:0];
        REG_QUARTER_TURNS:   cfg_q.quarter_turns   <= pwdata[1:0];
        REG_FLIP_VERTICAL:   cfg_q.flip_vertical   <= pwdata[0];
        REG_FLIP_HORIZONTAL: cfg_q.flip_horizontal <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PLANE_WIDTH:     prdata = DATA_W'(cfg_q.plane_width);
      REG_PLANE_HEIGHT:    prdata = DATA_W'(cfg_q.plane_height);
      REG_QUARTER_TURNS:   prdata = DATA_W'(cfg_q.quarter_turns);
      REG_FLIP_VERTICAL:   prdata = DATA_W'(cfg_q.flip_vertical);
      REG_FLIP_HORIZONTAL: prdata = DATA_W'(cfg_q.flip_horizontal);
      default:             prdata = '0;
    endcase
  end

  logic    push, queue_ready, q_valid, q_pop;
  q_item_t push_item, q_item;

  prfa_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pixel_in_i       (pixel_in_i),
    .start_of_plane_i (start_of_plane_i),
    .queue_ready_i    (queue_ready),
    .push_o           (push),
    .item_o           (push_item)
  );

  prfa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .ready_o (queue_ready),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  prfa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .dest_index_o   (dest_index_o),
    .pixel_out_o    (pixel_out_o),
    .write_enable_o (write_enable_o),
    .end_of_plane_o (end_of_plane_o)
  );

endmodule

@@ rtl/prfa_front.sv @@
// ----------------------------------------------------------------------------
// prfa_front
// takes pixels, tracks row and column, tags the last pixel of the plane
// ----------------------------------------------------------------------------
module prfa_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  prfa_pkg::cfg_t           cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [prfa_pkg::PIX_W-1:0] pixel_in_i,
  input  logic                     start_of_plane_i,
  input  logic                     queue_ready_i,
  output logic                     push_o,
  output prfa_pkg::q_item_t        item_o
);
  import prfa_pkg::*;

  logic [CNT_W-1:0] row_q, row_d, col_q, col_d;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [CNT_W-1:0] r, c;
  logic             restart, col_end, row_end;

  assign w_eff = eff_dim(cfg_i.plane_width);
  assign h_eff = eff_dim(cfg_i.plane_height);

  // a start flag or counters left outside the plane start a new one
  assign restart = start_of_plane_i || ({1'b0, row_q} >= h_eff) || ({1'b0, col_q} >= w_eff);
  assign r = restart ? '0 : row_q;
  assign c = restart ? '0 : col_q;

  assign col_end = ({1'b0, c} + DIM_W'(1)) >= w_eff;
  assign row_end = ({1'b0, r} + DIM_W'(1)) >= h_eff;

  assign in_ready_o = queue_ready_i;
  assign push_o     = in_valid_i && queue_ready_i;

  always_comb begin
    item_o.pixel = pixel_in_i;
    item_o.row   = r;
    item_o.col   = c;
    item_o.last  = ({1'b0, r} == h_eff - DIM_W'(1)) && ({1'b0, c} == w_eff - DIM_W'(1));
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (push_o) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : r + CNT_W'(1);
      end else begin
        col_d = c + CNT_W'(1);
        row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

@@ rtl/prfa_queue.sv @@
// ----------------------------------------------------------------------------
// prfa_queue
// short fifo between the pixel front end and the address back end
// ----------------------------------------------------------------------------
module prfa_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  prfa_pkg::q_item_t item_i,
  output logic              ready_o,
  output logic              valid_o,
  output prfa_pkg::q_item_t item_o,
  input  logic              pop_i
);
  import prfa_pkg::*;

  q_item_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign ready_o = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign item_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ rtl/prfa_back.sv @@
// ----------------------------------------------------------------------------
// prfa_back
// four-stage address pipe: local coordinates, row/offset terms, multiply, sum
// ----------------------------------------------------------------------------
module prfa_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  prfa_pkg::cfg_t             cfg_i,
  input  logic                       q_valid_i,
  input  prfa_pkg::q_item_t          q_item_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [prfa_pkg::IDX_W-1:0] dest_index_o,
  output logic [prfa_pkg::PIX_W-1:0] pixel_out_o,
  output logic                       write_enable_o,
  output logic                       end_of_plane_o
);
  import prfa_pkg::*;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic signed [OFS_W-1:0] w_s, h_s;

  assign w_eff = eff_dim(cfg_i.plane_width);
  assign h_eff = eff_dim(cfg_i.plane_height);
  assign w_s   = $signed({1'b0, w_eff});
  assign h_s   = $signed({1'b0, h_eff});

  logic adv_a, adv_b, adv_m, adv_o;
  logic a_vld_q, b_vld_q, m_vld_q, o_vld_q;

  assign adv_o   = !o_vld_q || out_ready_i;
  assign adv_m   = !m_vld_q || adv_o;
  assign adv_b   = !b_vld_q || adv_m;
  assign adv_a   = !a_vld_q || adv_b;
  assign q_pop_o = q_valid_i && adv_a;

  // ---- stage a: fold rotation, square offset, local coordinates
  logic             quarter, swap, fv, fh, wide;
  logic [DIM_W-1:0] diff;
  logic [CNT_W-1:0] off;
  logic signed [OFS_W-1:0] r_s, c_s, off_s, lr, lc;

  assign quarter = cfg_i.quarter_turns[0];
  assign swap    = cfg_i.quarter_turns[1];
  assign fv      = cfg_i.flip_vertical ^ swap;
  assign fh      = cfg_i.flip_horizontal ^ swap;
  assign wide    = w_eff > h_eff;
  assign diff    = wide ? (w_eff - h_eff) : (h_eff - w_eff);
  assign off     = diff[DIM_W-1:1];
  assign r_s     = $signed({2'b00, q_item_i.row});
  assign c_s     = $signed({2'b00, q_item_i.col});
  assign off_s   = $signed({2'b00, off});

  always_comb begin
    lr = r_s;
    lc = c_s;
    if (quarter) begin
      if (wide) begin
        lc = c_s - off_s;
      end else begin
        lr = r_s - off_s;
      end
    end
  end

  logic signed [OFS_W-1:0] a_lr_q, a_lc_q;
  logic [CNT_W-1:0]        a_off_q;
  logic                    a_quarter_q, a_fv_q, a_fh_q, a_wide_q, a_last_q;
  logic [PIX_W-1:0]        a_pixel_q;

  // ---- stage b: bounds check, multiplier operand and additive term
  logic signed [OFS_W-1:0] side_s, aoff_s, ko, ao, k_s, t_s;
  logic                    we;

  assign side_s = a_wide_q ? h_s : w_s;
  assign aoff_s = $signed({2'b00, a_off_q});
  assign ko     = a_wide_q ? '0 : aoff_s;
  assign ao     = a_wide_q ? aoff_s : '0;

  always_comb begin
    we  = 1'b1;
    k_s = a_lr_q;
    t_s = a_lc_q;
    if (!a_quarter_q) begin
      k_s = a_fv_q ? (h_s - OFS_W'(1) - a_lr_q) : a_lr_q;
      t_s = a_fh_q ? (w_s - OFS_W'(1) - a_lc_q) : a_lc_q;
    end else begin
      we = !a_lr_q[OFS_W-1] && (a_lr_q < side_s) && !a_lc_q[OFS_W-1] && (a_lc_q < side_s);
      unique case ({a_fh_q, a_fv_q})
        2'b11: begin
          k_s = h_s - OFS_W'(1) - ko - a_lc_q;
          t_s = ao + a_lr_q;
        end
        2'b10: begin
          k_s = ko + a_lc_q;
          t_s = ao + a_lr_q;
        end
        2'b01: begin
          k_s = h_s - ko - a_lc_q;
          t_s = -ao - OFS_W'(1) - a_lr_q;
        end
        default: begin
          k_s = ko + OFS_W'(1) + a_lc_q;
          t_s = -ao - OFS_W'(1) - a_lr_q;
        end
      endcase
    end
  end

  logic [DIM_W-1:0]        b_k_q;
  logic signed [OFS_W-1:0] b_t_q;
  logic                    b_we_q, b_last_q;
  logic [PIX_W-1:0]        b_pixel_q;

  // ---- stage m: row product
  logic [2*DIM_W-1:0]      m_prod_q;
  logic signed [OFS_W-1:0] m_t_q;
  logic                    m_we_q, m_last_q;
  logic [PIX_W-1:0]        m_pixel_q;

  // ---- output register
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] o_idx_q;
  logic             o_we_q, o_last_q;
  logic [PIX_W-1:0] o_pixel_q;

  assign idx = m_we_q ? (m_prod_q[IDX_W-1:0] + {{(IDX_W-OFS_W){m_t_q[OFS_W-1]}}, m_t_q}) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (adv_a) begin
        a_vld_q <= q_valid_i;
      end
      if (adv_b) begin
        b_vld_q <= a_vld_q;
      end
      if (adv_m) begin
        m_vld_q <= b_vld_q;
      end
      if (adv_o) begin
        o_vld_q <= m_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a) begin
      a_lr_q      <= lr;
      a_lc_q      <= lc;
      a_off_q     <= off;
      a_quarter_q <= quarter;
      a_fv_q      <= fv;
      a_fh_q      <= fh;
      a_wide_q    <= wide;
      a_pixel_q   <= q_item_i.pixel;
      a_last_q    <= q_item_i.last;
    end
    if (adv_b) begin
      b_k_q     <= k_s[DIM_W-1:0];
      b_t_q     <= t_s;
      b_we_q    <= we;
      b_pixel_q <= a_pixel_q;
      b_last_q  <= a_last_q;
    end
    if (adv_m) begin
      m_prod_q  <= w_eff * b_k_q;
      m_t_q     <= b_t_q;
      m_we_q    <= b_we_q;
      m_pixel_q <= b_pixel_q;
      m_last_q  <= b_last_q;
    end
    if (adv_o) begin
      o_idx_q   <= idx;
      o_we_q    <= m_we_q;
      o_pixel_q <= m_pixel_q;
      o_last_q  <= m_last_q;
    end
  end

  assign out_valid_o    = o_vld_q;
  assign dest_index_o   = o_idx_q;
  assign pixel_out_o    = o_pixel_q;
  assign write_enable_o = o_we_q;
  assign end_of_plane_o = o_last_q;

endmodule

@@ rtl/prfa_checker.sv @@
// ----------------------------------------------------------------------------
// prfa_checker
// port-level checks on the address unit, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prfa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [prfa_pkg::IDX_W-1:0] dest_index_o,
  input logic [prfa_pkg::PIX_W-1:0] pixel_out_o,
  input logic                       write_enable_o,
  input logic                       end_of_plane_o
);
  import prfa_pkg::*;

  localparam int unsigned FLIGHT_W = $clog2(MAX_IN_FLIGHT + 2);

  logic [FLIGHT_W-1:0] in_flight_q, in_flight_d;
  logic                in_xfer, out_xfer;
  logic [IDX_W+PIX_W+1:0] out_payload;

  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_o && out_ready_i;
  assign out_payload = {dest_index_o, pixel_out_o, write_enable_o, end_of_plane_o};
  assign in_flight_d = in_flight_q + FLIGHT_W'(in_xfer) - FLIGHT_W'(out_xfer);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_flight_q <= '0;
    end else begin
      in_flight_q <= in_flight_d;
    end
  end

  `PRFA_ASSERT(a_idx_zero_when_masked, out_valid_o && !write_enable_o |-> dest_index_o == '0, "masked pixel carries a nonzero index")
  `PRFA_ASSERT_HOLD(a_out_hold, out_valid_o, out_ready_i, out_payload, "stalled result changed")
  `PRFA_ASSERT(a_flight_bound, in_flight_q <= FLIGHT_W'(MAX_IN_FLIGHT), "more pixels in flight than the pipe holds")
  `PRFA_ASSERT(a_out_has_source, out_valid_o |-> in_flight_q != '0, "result without a pending pixel")
  `PRFA_ASSERT(a_empty_ready, in_flight_q == '0 |-> in_ready_o, "empty unit refuses a transfer")

endmodule

bind plane_rotate_flip_addressing_unit prfa_checker u_prfa_checker (.*);

@@ bench/tb_plane_rotate_flip_addressing_unit.sv @@
// ----------------------------------------------------------------------------
// tb_plane_rotate_flip_addressing_unit
// streams pixels through the rotate/flip address unit and checks every result
// ----------------------------------------------------------------------------
// A behavioral copy of the raster counters and the address mapping predicts
// each write address. The reset register values are read back first, then come
// directed corners and random planes of random geometry, with random idling on
// both sides. The run closes with two full-rate planes. Register reads are checked along the way.
module tb_plane_rotate_flip_addressing_unit;
  import prfa_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_PIXELS  = 920;
  localparam int unsigned DRAIN_CYCLES   = 12;

  typedef struct packed {
    logic [IDX_W-1:0] dest_index;
    logic [PIX_W-1:0] pixel_out;
    logic             write_enable;
    logic             end_of_plane;
  } pixel_write_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [PIX_W-1:0]  pixel_in_i = '0;
  logic              start_of_plane_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b1;
  logic [IDX_W-1:0]  dest_index_o;
  logic [PIX_W-1:0]  pixel_out_o;
  logic              write_enable_o;
  logic              end_of_plane_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // shadow of the register file and the raster position
  logic [DIM_W-1:0] cfg_width = RST_PLANE_WIDTH;
  logic [DIM_W-1:0] cfg_height = RST_PLANE_HEIGHT;
  logic [1:0]       cfg_turns = '0;
  logic             cfg_flip_v = 1'b0;
  logic             cfg_flip_h = 1'b0;
  logic [CNT_W-1:0] row_pos = '0;
  logic [CNT_W-1:0] col_pos = '0;

  pixel_write_t expected_writes[$];

  logic        idle_enable = 1'b1;
  int unsigned error_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned writes_checked = 0;
  int unsigned masked_writes = 0;
  int unsigned plane_ends = 0;
  int unsigned geometries = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;

  plane_rotate_flip_addressing_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pixel_in_i       (pixel_in_i),
    .start_of_plane_i (start_of_plane_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .dest_index_o     (dest_index_o),
    .pixel_out_o      (pixel_out_o),
    .write_enable_o   (write_enable_o),
    .end_of_plane_o   (end_of_plane_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // zero counts as one, anything past the maximum as the maximum
  function automatic longint plane_extent(input logic [DIM_W-1:0] d);
    if (d == '0) begin
      return 1;
    end else if (d > DIM_W'(MAX_DIM)) begin
      return longint'(MAX_DIM);
    end
    return longint'(d);
  endfunction

  function automatic logic [DATA_W-1:0] stored_register(input logic [2:0] idx);
    logic [DATA_W-1:0] v;
    v = '0;
    case (idx)
      REG_PLANE_WIDTH:     v = DATA_W'(cfg_width);
      REG_PLANE_HEIGHT:    v = DATA_W'(cfg_height);
      REG_QUARTER_TURNS:   v = DATA_W'(cfg_turns);
      REG_FLIP_VERTICAL:   v = DATA_W'(cfg_flip_v);
      REG_FLIP_HORIZONTAL: v = DATA_W'(cfg_flip_h);
      default: v = '0;
    endcase
    return v;
  endfunction

  // advances the raster position and returns the write this pixel causes
  function automatic pixel_write_t predict_write(input logic [PIX_W-1:0] pix,
                                                 input logic plane_start);
    longint w, h, r, c, idx, off, side, lr, lc, base, col_step, row_step;
    logic [1:0] turns;
    logic fv, fh, we, wide;
    pixel_write_t res;
    w = plane_extent(cfg_width);
    h = plane_extent(cfg_height);
    turns = cfg_turns;
    fv = cfg_flip_v;
    fh = cfg_flip_h;
    idx = 0;
    we = 1'b1;
    if (plane_start || longint'(row_pos) >= h || longint'(col_pos) >= w) begin
      row_pos = '0;
      col_pos = '0;
    end
    r = longint'(row_pos);
    c = longint'(col_pos);
    // half turns fold into the mirrored lower rotation
    if (turns >= 2'd2) begin
      turns = turns - 2'd2;
      fv = !fv;
      fh = !fh;
    end
    if (turns == 2'd0) begin
      idx = (fv ? h - 1 - r : r) * w + (fh ? w - 1 - c : c);
    end else begin
      wide = (w > h);
      off = wide ? (w - h) / 2 : (h - w) / 2;
      side = wide ? h : w;
      lr = wide ? r : r - off;
      lc = wide ? c - off : c;
      col_step = fv ? -w : w;
      row_step = fh ? 1 : -1;
      if (lr < 0 || lr >= side || lc < 0 || lc >= side) begin
        we = 1'b0;
      end else begin
        if (fh) begin
          if (fv) base = wide ? w * (h - 1) + off : w * (h - off - 1);
          else    base = wide ? off : w * off;
        end else begin
          if (fv) base = wide ? w * h - off - 1 : w * (h - off) - 1;
          else    base = wide ? w - off - 1 : w * (off + 1) - 1;
        end
        idx = base + lr * row_step + lc * col_step;
      end
    end
    res.dest_index = we ? IDX_W'(idx) : '0;
    res.pixel_out = pix;
    res.write_enable = we;
    res.end_of_plane = (r == h - 1) && (c == w - 1);
    if (c + 1 >= w) begin
      col_pos = '0;
      if (r + 1 >= h) row_pos = '0;
      else row_pos = CNT_W'(r + 1);
    end else begin
      col_pos = CNT_W'(c + 1);
    end
    return res;
  endfunction

  // output side: random stall bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_writes
    pixel_write_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_writes.size() == 0) begin
        $error("unexpected result: dest_index %0d pixel_out %0d", dest_index_o, pixel_out_o);
        error_count++;
      end else begin
        exp_w = expected_writes.pop_front();
        writes_checked++;
        if (!exp_w.write_enable) masked_writes++;
        if (exp_w.end_of_plane) plane_ends++;
        if (dest_index_o !== exp_w.dest_index) begin
          $error("dest_index: expected %0d, got %0d", exp_w.dest_index, dest_index_o);
          error_count++;
        end
        if (pixel_out_o !== exp_w.pixel_out) begin
          $error("pixel_out: expected %0d, got %0d", exp_w.pixel_out, pixel_out_o);
          error_count++;
        end
        if (write_enable_o !== exp_w.write_enable) begin
          $error("write_enable: expected %0b, got %0b", exp_w.write_enable, write_enable_o);
          error_count++;
        end
        if (end_of_plane_o !== exp_w.end_of_plane) begin
          $error("end_of_plane: expected %0b, got %0b", exp_w.end_of_plane, end_of_plane_o);
          error_count++;
        end
      end
    end
  end

  // ends the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("no transfer for %0d cycles", quiet_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PLANE_WIDTH:     cfg_width = value[DIM_W-1:0];
      REG_PLANE_HEIGHT:    cfg_height = value[DIM_W-1:0];
      REG_QUARTER_TURNS:   cfg_turns = value[1:0];
      REG_FLIP_VERTICAL:   cfg_flip_v = value[0];
      REG_FLIP_HORIZONTAL: cfg_flip_h = value[0];
      default: ;
    endcase
  endtask

  task automatic check_registers();
    logic [DATA_W-1:0] want;
    for (int i = REG_PLANE_WIDTH; i <= REG_FLIP_HORIZONTAL; i++) begin
      want = stored_register(3'(i));
      @(posedge clk_i);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {3'(i), 2'b00};
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      if (prdata !== want) begin
        $error("prdata of register %0d: expected %0h, got %0h", i, want, prdata);
        error_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // writes the whole geometry, now and then with junk above the register width
  task automatic program_plane(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                               input logic [1:0] turns, input logic fv, input logic fh);
    logic [DATA_W-1:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom()) : '0;
    apb_write(REG_PLANE_WIDTH, (junk & ~DATA_W'(32'h1fff)) | DATA_W'(w));
    apb_write(REG_PLANE_HEIGHT, (junk & ~DATA_W'(32'h1fff)) | DATA_W'(h));
    apb_write(REG_QUARTER_TURNS, (junk & ~DATA_W'(32'h3)) | DATA_W'(turns));
    apb_write(REG_FLIP_VERTICAL, (junk & ~DATA_W'(32'h1)) | DATA_W'(fv));
    apb_write(REG_FLIP_HORIZONTAL, (junk & ~DATA_W'(32'h1)) | DATA_W'(fh));
    check_registers();
    geometries++;
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic plane_start);
    pixel_write_t next_write;
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= pix;
    start_of_plane_i <= plane_start;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    next_write = predict_write(pix, plane_start);
    expected_writes.insert(expected_writes.size(), next_write);
    pixels_sent++;
  endtask

  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DIM_W-1:0] pick_odd_dim();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return DIM_W'(1);
      2: return DIM_W'(2);
      3: return DIM_W'(MAX_DIM);
      4: return DIM_W'($urandom_range(MAX_DIM + 1, 8191));
      default: return DIM_W'($urandom_range(13, 64));
    endcase
  endfunction

  task automatic test_register_reset();
    check_registers();
  endtask

  task automatic test_directed_corners();
    // reset geometry with the pixel extremes
    send_pixel('0, 1'b1);
    send_pixel('1, 1'b0);
    wait_for_idle();
    // half turn, then the counters roll over into a second plane on their own
    program_plane(DIM_W'(2), DIM_W'(2), 2'd2, 1'b0, 1'b1);
    for (int i = 0; i < 6; i++) send_pixel(PIX_W'(i * 41 + 3), i == 0);
    wait_for_idle();
    // tall plane, three quarter turns: only the centered square is written
    program_plane(DIM_W'(2), DIM_W'(4), 2'd3, 1'b1, 1'b0);
    for (int i = 0; i < 8; i++) send_pixel(PIX_W'($urandom()), i == 0);
    wait_for_idle();
    // zero width and an oversized height, left unfinished
    program_plane('0, 13'h1fff, 2'd1, 1'b0, 1'b0);
    for (int i = 0; i < 3; i++) send_pixel(PIX_W'($urandom()), 1'b0);
    wait_for_idle();
    // row position now lies outside the new plane and must restart
    program_plane(13'd5000, DIM_W'(1), 2'd0, 1'b1, 1'b1);
    for (int i = 0; i < 3; i++) send_pixel(PIX_W'($urandom()), 1'b0);
    wait_for_idle();
  endtask

  task automatic run_random_phase();
    logic [DIM_W-1:0] w, h;
    logic plane_start;
    int unsigned plane_px, n, planes, style;
    w = DIM_W'($urandom_range(2, 10));
    h = DIM_W'($urandom_range(2, 10));
    case ($urandom_range(0, 9))
      0: w = pick_odd_dim();
      1: h = pick_odd_dim();
      2: begin
        w = pick_odd_dim();
        h = pick_odd_dim();
      end
      default: ;
    endcase
    program_plane(w, h, 2'($urandom()), 1'($urandom()), 1'($urandom()));
    plane_px = int'(plane_extent(w) * plane_extent(h));
    style = $urandom_range(0, 9);
    if (plane_px > 256) begin
      // big planes: only the first rows
      n = $urandom_range(10, 50);
      for (int i = 0; i < n; i++) send_pixel(PIX_W'($urandom()), i == 0 && style != 0);
    end else begin
      planes = $urandom_range(1, 3);
      for (int p = 0; p < planes; p++) begin
        n = (style == 7) ? $urandom_range(1, plane_px) : plane_px;
        for (int i = 0; i < n; i++) begin
          plane_start = (i == 0) && (style != 9) && (p == 0 || $urandom_range(0, 1) == 1);
          if (style == 8 && $urandom_range(0, 7) == 0) plane_start = 1'b1;
          send_pixel(PIX_W'($urandom()), plane_start);
        end
      end
    end
    wait_for_idle();
  endtask

  task automatic test_random_planes();
    while (pixels_sent < RANDOM_PIXELS) run_random_phase();
  endtask

  task automatic test_full_rate_planes();
    idle_enable = 1'b0;
    program_plane(DIM_W'(14), DIM_W'(9), 2'd1, 1'b0, 1'b1);
    for (int i = 0; i < 14 * 9; i++) send_pixel(PIX_W'($urandom()), i == 0);
    wait_for_idle();
    program_plane(DIM_W'(7), DIM_W'(12), 2'd3, 1'b1, 1'b0);
    for (int i = 0; i < 7 * 12; i++) send_pixel(PIX_W'($urandom()), i == 0);
    wait_for_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_register_reset();
    test_directed_corners();
    test_random_planes();
    test_full_rate_planes();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("pixels %0d, results checked %0d, masked %0d, plane ends %0d",
             pixels_sent, writes_checked, masked_writes, plane_ends);
    $display("geometries programmed %0d, errors %0d", geometries, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
